### design/bounded_sequence_list_engine_macros.svh
// Assertion macros for the bounded sequence list engine.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_MACROS_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_MACROS_SVH

// expr holds at every clock edge outside reset
`define BSLE_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define BSLE_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define BSLE_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bsle_pkg.sv
// Shared types, codes and constants for the bounded sequence list engine.
// No dependencies.
package bsle_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VALUE_W   = 32;
	localparam int CMD_W     = 3;
	localparam int POS_W     = 5;
	localparam int STAT_W    = 3;
	localparam int LEN_W     = 5;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_VAL   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_INS_ORD   = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  length;
	} rsp_t;

	typedef enum logic [1:0] {
		TGT_ZERO,
		TGT_COUNT,
		TGT_POS,
		TGT_HIT
	} tgt_sel_t;

	typedef struct packed {
		logic              load_item;
		logic              search_start;
		logic              search_en;
		logic              start_up;
		logic              start_dn;
		logic              shift_en;
		logic              put_value;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              out_load;
		tgt_sel_t          tgt_sel;
		logic [STAT_W-1:0] out_status;
	} ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             empty;
		logic             pos_ok;
		logic             hit;
		logic             exhausted;
		logic             shift_done;
		logic             out_free;
	} sts_t;

endpackage

### design/bounded_sequence_list_engine.sv
// Top level of the bounded sequence list engine: controller plus datapath.
// Depends on bsle_pkg, bsle_ctl and bsle_dp.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   req     | req_valid/req_stall  | req_t: command, value, position
//   rsp     | rsp_valid/rsp_stall  | rsp_t: status, length
//
// One command is in work at a time; the next is taken once the result is
// loaded into the output register, even while that result is still stalled.
// A command that neither scans nor shifts passes only the decide and finish states; a
// scan from the front checks the elements in turn, and a shift moves the tail one
// element at a time before the finish state loads the result, waiting on output stalls.
// Reset clears the count and all control state; the element store needs no clearing pass.
module bounded_sequence_list_engine import bsle_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_t ctl;
	sts_t sts;

	bsle_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	bsle_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

### design/bsle_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bsle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/bsle_dp.sv
// Datapath: element store, count, search and shift pointers, result register.
// Depends on bsle_pkg, bsle_ram and the assertion macro header.
`include "bounded_sequence_list_engine_macros.svh"

module bsle_dp import bsle_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  ctl_t ctl,
	output sts_t sts,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	req_t              item_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     left_q;
	logic [CW-1:0]     tgt_q;
	logic              dir_up_q;
	logic              chk_vld_s1;
	logic [CW-1:0]     chk_idx_s1;
	logic              mv_vld_s1;
	logic [CW-1:0]     mv_addr_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [CW-1:0]      tgt_n;
	logic [VALUE_W-1:0] rdata;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] wdata;
	logic               match;
	logic               ptr_in_range;

	always_comb begin
		unique case (ctl.tgt_sel)
			TGT_ZERO:  tgt_n = '0;
			TGT_COUNT: tgt_n = cnt_q;
			TGT_POS:   tgt_n = CW'(item_q.position - POS_W'(1));
			TGT_HIT:   tgt_n = chk_idx_s1;
		endcase
	end

	assign ptr_in_range = (ptr_q < cnt_q);
	assign match = (item_q.command == CMD_DEL_VAL) ? (rdata == item_q.value)
		: ($signed(rdata) >= item_q.value);

	assign we    = mv_vld_s1 | ctl.put_value;
	assign waddr = mv_vld_s1 ? mv_addr_s1[AW-1:0] : tgt_q[AW-1:0];
	assign wdata = mv_vld_s1 ? rdata : item_q.value;

	bsle_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	assign sts.cmd        = item_q.command;
	assign sts.full       = (cnt_q == CW'(DEPTH));
	assign sts.empty      = (cnt_q == '0);
	assign sts.pos_ok     = (item_q.position != '0)
		&& (CMPW'(item_q.position) <= CMPW'(cnt_q) + CMPW'(1));
	assign sts.hit        = chk_vld_s1 && match;
	assign sts.exhausted  = !chk_vld_s1 && !ptr_in_range;
	assign sts.shift_done = (left_q == '0) && !mv_vld_s1;
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			item_q <= req;
		end
		chk_idx_s1 <= ptr_q;
		mv_addr_s1 <= dir_up_q ? (ptr_q + CW'(1)) : (ptr_q - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			ptr_q      <= '0;
			left_q     <= '0;
			tgt_q      <= '0;
			dir_up_q   <= 1'b0;
			chk_vld_s1 <= 1'b0;
			mv_vld_s1  <= 1'b0;
		end else begin
			if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end

			priority if (ctl.start_up) begin
				tgt_q    <= tgt_n;
				ptr_q    <= cnt_q - CW'(1);
				left_q   <= cnt_q - tgt_n;
				dir_up_q <= 1'b1;
			end else if (ctl.start_dn) begin
				tgt_q    <= tgt_n;
				ptr_q    <= tgt_n + CW'(1);
				left_q   <= cnt_q - tgt_n - CW'(1);
				dir_up_q <= 1'b0;
			end else if (ctl.search_start) begin
				ptr_q <= '0;
			end else if (ctl.search_en && ptr_in_range) begin
				ptr_q <= ptr_q + CW'(1);
			end else if (ctl.shift_en && (left_q != '0)) begin
				left_q <= left_q - CW'(1);
				ptr_q  <= dir_up_q ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));
			end else begin
				ptr_q <= ptr_q;
			end

			chk_vld_s1 <= ctl.search_en && ptr_in_range;
			mv_vld_s1  <= ctl.shift_en && (left_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_q.status <= ctl.out_status;
			rsp_q.length <= LEN_W'(cnt_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BSLE_CHECK(a_cnt_bound, cnt_q <= CW'(DEPTH), "element count above depth")
	`BSLE_IMPLY(a_wr_port, mv_vld_s1, !ctl.put_value, "move and insert write collide")
	`BSLE_NEXT(a_cnt_inc, ctl.cnt_inc, cnt_q == $past(cnt_q) + CW'(1), "count did not step up")
	`BSLE_IMPLY(a_put_room, ctl.put_value, cnt_q < CW'(DEPTH), "insert into full store")

endmodule

### design/bsle_ctl.sv
// Controller state machine: sequences decode, search, shift and result.
// Depends on bsle_pkg and the assertion macro header.
`include "bounded_sequence_list_engine_macros.svh"

module bsle_ctl import bsle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_SHUP   = 3'd3;
	localparam logic [2:0] S_SHDN   = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]        state_q;
	logic [2:0]        state_n;
	logic [STAT_W-1:0] status_q;
	logic [STAT_W-1:0] status_n;
	logic              is_ins;

	assign is_ins = (sts.cmd == CMD_INS_FRONT) || (sts.cmd == CMD_INS_REAR)
		|| (sts.cmd == CMD_INS_POS) || (sts.cmd == CMD_INS_ORD);

	always_comb begin
		ctl      = '0;
		state_n  = state_q;
		status_n = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load_item = 1'b1;
					state_n       = S_DECIDE;
				end
			end
			S_DECIDE: begin
				status_n = ST_OK;
				state_n  = S_FINISH;
				priority if (is_ins && sts.full) begin
					status_n = ST_FULL;
				end else begin
					unique case (sts.cmd)
						CMD_INS_FRONT: begin
							ctl.tgt_sel  = TGT_ZERO;
							ctl.start_up = 1'b1;
							state_n      = S_SHUP;
						end
						CMD_INS_REAR: begin
							ctl.tgt_sel  = TGT_COUNT;
							ctl.start_up = 1'b1;
							state_n      = S_SHUP;
						end
						CMD_INS_POS: begin
							if (sts.pos_ok) begin
								ctl.tgt_sel  = TGT_POS;
								ctl.start_up = 1'b1;
								state_n      = S_SHUP;
							end else begin
								status_n = ST_BADPOS;
							end
						end
						CMD_DEL_FRONT: begin
							if (sts.empty) begin
								status_n = ST_EMPTY;
							end else begin
								ctl.tgt_sel  = TGT_ZERO;
								ctl.start_dn = 1'b1;
								state_n      = S_SHDN;
							end
						end
						CMD_DEL_REAR: begin
							if (sts.empty) begin
								status_n = ST_EMPTY;
							end else begin
								ctl.cnt_dec = 1'b1;
							end
						end
						CMD_DEL_VAL: begin
							if (sts.empty) begin
								status_n = ST_EMPTY;
							end else begin
								ctl.search_start = 1'b1;
								state_n          = S_SEARCH;
							end
						end
						CMD_INS_ORD: begin
							ctl.search_start = 1'b1;
							state_n          = S_SEARCH;
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				priority if (sts.hit) begin
					ctl.tgt_sel = TGT_HIT;
					if (sts.cmd == CMD_DEL_VAL) begin
						ctl.start_dn = 1'b1;
						state_n      = S_SHDN;
					end else begin
						ctl.start_up = 1'b1;
						state_n      = S_SHUP;
					end
				end else if (sts.exhausted) begin
					if (sts.cmd == CMD_DEL_VAL) begin
						status_n = ST_NOTFOUND;
						state_n  = S_FINISH;
					end else begin
						ctl.tgt_sel  = TGT_COUNT;
						ctl.start_up = 1'b1;
						state_n      = S_SHUP;
					end
				end else begin
					ctl.search_en = 1'b1;
				end
			end
			S_SHUP: begin
				ctl.shift_en = 1'b1;
				if (sts.shift_done) begin
					ctl.put_value = 1'b1;
					ctl.cnt_inc   = 1'b1;
					state_n       = S_FINISH;
				end
			end
			S_SHDN: begin
				ctl.shift_en = 1'b1;
				if (sts.shift_done) begin
					ctl.cnt_dec = 1'b1;
					state_n     = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
		ctl.out_status = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_n;
			status_q <= status_n;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	`BSLE_IMPLY(a_load_free, ctl.out_load, sts.out_free, "result loaded over a pending one")
	`BSLE_CHECK(a_one_start,
		$onehot0({ctl.load_item, ctl.search_start, ctl.start_up, ctl.start_dn}),
		"conflicting sequencer starts")
	`BSLE_NEXT(a_accept_decide, ctl.load_item, state_q == S_DECIDE, "accept not followed by decode")

endmodule
